@@ hdl/prq_pkg.sv @@
// ----------------------------------------------------------------------------
// prq_pkg: shared definitions of the priority run queue scheduler
// Widths, default sizes, operation and status codes and the sequencer states.
// ----------------------------------------------------------------------------
package prq_pkg;

   // Default sizes of the queue and of a priority value.
   localparam int MAX_TASKS_DEF = 32;
   localparam int PRIO_BITS_DEF = 8;

   // Task identifiers, the runnable counter and the width of the input priority.
   localparam int ID_W      = 5;
   localparam int NUM_IDS   = 32;
   localparam int COUNT_W   = 6;
   localparam int IN_PRIO_W = 8;

   // Value of a front mark that asks for insertion ahead of equal priorities.
   localparam logic FRONT_MARK_SET = 1'b1;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_PICK    = 2'd1,
      OP_TICK    = 2'd2,
      OP_STEAL   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_IGNORED = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ_SCAN,
      S_ENQ_CMP,
      S_PICK_HEAD,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_STEAL
   } state_type;

endpackage

@@ hdl/priority_run_queue_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// priority_run_queue_scheduler_core: sorted run queue of a single CPU
// Keeps queued tasks sorted by priority in a single-port memory and serves
// enqueue, pick, tick and steal operations under a small sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and its one result is
// shown for exactly one cycle with rsp_strobe high; the receiver cannot stall
// it, so it must sample the result in that cycle. Tick, an enqueue that is
// ignored or dropped, and a pick or steal on an empty queue never raise busy:
// the result appears in the cycle after the item is taken. A steal keeps
// busy high for one cycle. An enqueue keeps busy high while the queued
// entries that must stand behind the new task move one place back to make
// room, and a pick while the remaining entries move one place forward. The
// queue memory reads one entry per cycle with registered read data, and each
// moved entry is first read and then written back in its new place.
// The memory needs no clearing after reset; busy is low from the first cycle.
// The preemption enable is written through csr_we and csr_wdata and resets to
// one. The user must write it only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module priority_run_queue_scheduler_core #(
   parameter int MAX_TASKS = prq_pkg::MAX_TASKS_DEF,
   parameter int PRIO_BITS = prq_pkg::PRIO_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_opcode,
   input  logic [prq_pkg::ID_W-1:0]     req_task_id,
   input  logic [prq_pkg::IN_PRIO_W-1:0] req_task_prio,
   input  logic                         req_task_is_idle,
   input  logic                         req_was_runnable,
   input  logic                         req_last_tick,

   output logic                         rsp_strobe,
   output logic [prq_pkg::ID_W-1:0]     rsp_out_task_id,
   output logic                         rsp_out_valid,
   output logic                         rsp_resched_request,
   output logic [prq_pkg::COUNT_W-1:0]  rsp_runnable_count,
   output logic [1:0]                   rsp_status,

   input  logic                         csr_we,
   input  logic                         csr_wdata
);

   localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W   = $clog2(MAX_TASKS + 1);
   localparam int ENTRY_W = prq_pkg::ID_W + PRIO_BITS;
   localparam int ID_W    = prq_pkg::ID_W;
   localparam int NUM_IDS = prq_pkg::NUM_IDS;
   localparam int COUNT_W = prq_pkg::COUNT_W;

   // Queue memory: each entry holds the task id above its priority.
   logic [ENTRY_W-1:0] queue_mem [MAX_TASKS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   // Control state.
   prq_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]        len_ff, len_in;
   logic [NUM_IDS-1:0]      queued_ff, queued_in;
   logic [NUM_IDS-1:0]      front_ff, front_in;
   logic [ID_W-1:0]         cur_id_ff, cur_id_in;
   logic [PRIO_BITS-1:0]    cur_prio_ff, cur_prio_in;
   logic                    cur_idle_ff, cur_idle_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    resched_ff, resched_in;
   logic                    preempt_ff, preempt_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;

   // Item and result registers.
   logic [CNT_W-1:0]        ptr_ff, ptr_in;
   logic [ID_W-1:0]         id_ff, id_in;
   logic [PRIO_BITS-1:0]    prio_ff, prio_in;
   logic                    was_run_ff, was_run_in;
   logic                    front_sel_ff, front_sel_in;
   logic [ID_W-1:0]         rsp_id_ff, rsp_id_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   prq_pkg::status_type     rsp_status_ff, rsp_status_in;

   logic                    enq_done;
   logic [CNT_W-1:0]        len_m1;
   logic [CNT_W-1:0]        ptr_m1;
   logic [ID_W-1:0]         rd_id;
   logic [PRIO_BITS-1:0]    rd_prio;
   logic                    move_back;

   assign len_m1  = len_ff - CNT_W'(1);
   assign ptr_m1  = ptr_ff - CNT_W'(1);
   assign rd_id   = rd_data_ff[ENTRY_W-1 -: ID_W];
   assign rd_prio = rd_data_ff[PRIO_BITS-1:0];

   // An entry moves back when the new task must stand ahead of it. With the
   // front mark set, the new task also goes ahead of equal priorities.
   assign move_back = front_sel_ff ? (rd_prio >= prio_ff) : (rd_prio > prio_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= queue_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= prq_pkg::S_IDLE;
         len_ff        <= '0;
         queued_ff     <= '0;
         front_ff      <= '0;
         cur_id_ff     <= '0;
         cur_prio_ff   <= '0;
         cur_idle_ff   <= 1'b1;
         count_ff      <= '0;
         resched_ff    <= 1'b0;
         preempt_ff    <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         queued_ff     <= queued_in;
         front_ff      <= front_in;
         cur_id_ff     <= cur_id_in;
         cur_prio_ff   <= cur_prio_in;
         cur_idle_ff   <= cur_idle_in;
         count_ff      <= count_in;
         resched_ff    <= resched_in;
         preempt_ff    <= preempt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      id_ff         <= id_in;
      prio_ff       <= prio_in;
      was_run_ff    <= was_run_in;
      front_sel_ff  <= front_sel_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      queued_in     = queued_ff;
      front_in      = front_ff;
      cur_id_in     = cur_id_ff;
      cur_prio_in   = cur_prio_ff;
      cur_idle_in   = cur_idle_ff;
      count_in      = count_ff;
      resched_in    = resched_ff;
      preempt_in    = csr_we ? csr_wdata : preempt_ff;
      ptr_in        = ptr_ff;
      id_in         = id_ff;
      prio_in       = prio_ff;
      was_run_in    = was_run_ff;
      front_sel_in  = front_sel_ff;
      rsp_strobe_in = 1'b0;
      rsp_id_in     = '0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = prq_pkg::STAT_DONE;
      rd_addr       = '0;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = rd_data_ff;
      enq_done      = 1'b0;

      case (state_ff)
         prq_pkg::S_IDLE: begin
            // Prefetch the tail for a steal; a pick wants the head at address 0.
            if (req_opcode != prq_pkg::OP_PICK && len_ff != '0) begin
               rd_addr = len_m1[IDX_W-1:0];
            end
            if (start) begin
               id_in      = req_task_id;
               prio_in    = PRIO_BITS'(req_task_prio);
               was_run_in = req_was_runnable;
               case (prq_pkg::op_type'(req_opcode))
                  prq_pkg::OP_ENQUEUE: begin
                     if (queued_ff[req_task_id] || req_task_is_idle) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = prq_pkg::STAT_IGNORED;
                     end else if (len_ff == CNT_W'(MAX_TASKS)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = prq_pkg::STAT_FULL;
                     end else begin
                        front_sel_in          = front_ff[req_task_id];
                        front_in[req_task_id] = 1'b0;
                        ptr_in                = len_ff;
                        state_in              = prq_pkg::S_ENQ_SCAN;
                     end
                  end
                  prq_pkg::OP_PICK: begin
                     if (len_ff == '0) begin
                        cur_id_in     = '0;
                        cur_prio_in   = '0;
                        cur_idle_in   = 1'b1;
                        resched_in    = 1'b0;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = prq_pkg::S_PICK_HEAD;
                     end
                  end
                  prq_pkg::OP_TICK: begin
                     if (!cur_idle_ff && req_last_tick && count_ff != '0) begin
                        count_in = count_ff - COUNT_W'(1);
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  prq_pkg::OP_STEAL: begin
                     if (len_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = prq_pkg::S_STEAL;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         prq_pkg::S_ENQ_SCAN: begin
            if (ptr_ff == '0) begin
               enq_done = 1'b1;
            end else begin
               rd_addr  = ptr_m1[IDX_W-1:0];
               state_in = prq_pkg::S_ENQ_CMP;
            end
         end
         prq_pkg::S_ENQ_CMP: begin
            if (move_back) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_ff[IDX_W-1:0];
               mem_wdata = rd_data_ff;
               ptr_in    = ptr_m1;
               state_in  = prq_pkg::S_ENQ_SCAN;
            end else begin
               enq_done = 1'b1;
            end
         end
         prq_pkg::S_PICK_HEAD: begin
            cur_id_in        = rd_id;
            cur_prio_in      = rd_prio;
            cur_idle_in      = 1'b0;
            queued_in[rd_id] = 1'b0;
            id_in            = rd_id;
            ptr_in           = CNT_W'(1);
            state_in         = prq_pkg::S_SHIFT_RD;
         end
         prq_pkg::S_SHIFT_RD: begin
            if (ptr_ff >= len_ff) begin
               len_in        = len_m1;
               resched_in    = 1'b0;
               rsp_strobe_in = 1'b1;
               rsp_id_in     = id_ff;
               rsp_valid_in  = 1'b1;
               state_in      = prq_pkg::S_IDLE;
            end else begin
               rd_addr  = ptr_ff[IDX_W-1:0];
               state_in = prq_pkg::S_SHIFT_WR;
            end
         end
         prq_pkg::S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_m1[IDX_W-1:0];
            mem_wdata = rd_data_ff;
            ptr_in    = ptr_ff + CNT_W'(1);
            state_in  = prq_pkg::S_SHIFT_RD;
         end
         prq_pkg::S_STEAL: begin
            len_in           = len_m1;
            queued_in[rd_id] = 1'b0;
            if (count_ff != '0) begin
               count_in = count_ff - COUNT_W'(1);
            end
            rsp_strobe_in = 1'b1;
            rsp_id_in     = rd_id;
            rsp_valid_in  = 1'b1;
            state_in      = prq_pkg::S_IDLE;
         end
         default: begin
            state_in = prq_pkg::S_IDLE;
         end
      endcase

      // Place the new task in the hole left by the entries moved back.
      if (enq_done) begin
         mem_we           = 1'b1;
         mem_waddr        = ptr_ff[IDX_W-1:0];
         mem_wdata        = {id_ff, prio_ff};
         len_in           = len_ff + CNT_W'(1);
         queued_in[id_ff] = 1'b1;
         if (!was_run_ff) begin
            if (count_ff != '1) begin
               count_in = count_ff + COUNT_W'(1);
            end
            // A more urgent wakeup preempts a running task, which then goes
            // back ahead of its equals on its next enqueue.
            if (preempt_ff && !cur_idle_ff && prio_ff < cur_prio_ff) begin
               resched_in          = 1'b1;
               front_in[cur_id_ff] = prq_pkg::FRONT_MARK_SET;
            end
         end
         rsp_strobe_in = 1'b1;
         state_in      = prq_pkg::S_IDLE;
      end
   end

   assign busy                = (state_ff != prq_pkg::S_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_out_task_id     = rsp_id_ff;
   assign rsp_out_valid       = rsp_valid_ff;
   assign rsp_resched_request = resched_ff;
   assign rsp_runnable_count  = count_ff;
   assign rsp_status          = rsp_status_ff;

`ifndef SYNTHESIS
   // Between items every queued task has its mark set, and no other task
   // does. A pick clears the head's mark before it shortens the queue.
   a_marks_match_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prq_pkg::S_IDLE) |-> ($countones(queued_ff) == int'(len_ff)))
      else $error("queued marks disagree with queue length");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CNT_W'(MAX_TASKS))
      else $error("queue length beyond capacity");

   // A result is only shown once the sequencer is back at rest.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == prq_pkg::S_IDLE)
      else $error("result shown while busy");

   // An accepted item either starts work or answers at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted item produced neither work nor a result");
`endif

endmodule

@@ tb/tb_priority_run_queue_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// tb_priority_run_queue_scheduler_core: self-checking bench of the run queue
// Drives enqueue, pick, tick and steal items from a prepared list, keeps its
// own sorted run queue to work out every result, and checks each strobed
// result against the oldest prediction while the sender idles at random.
// ----------------------------------------------------------------------------
module tb_priority_run_queue_scheduler_core;

   timeunit 1ns;
   timeprecision 1ps;

   // A pause counts its settle time only once no result is outstanding and busy is low.
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 80;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_MAX    = 10;

   // Kinds of entries in the list of pending work. A pause waits until every
   // predicted result has arrived; a register write always follows a pause.
   typedef enum logic [1:0] {
      CMD_ITEM,
      CMD_PAUSE,
      CMD_CSR
   } cmd_kind_type;

   typedef struct {
      cmd_kind_type                  kind;
      prq_pkg::op_type               op;
      logic [prq_pkg::ID_W-1:0]      id;
      logic [prq_pkg::IN_PRIO_W-1:0] prio;
      logic                          idle;
      logic                          was_run;
      logic                          last;
      logic                          csr_val;
      int                            gap_pct;
   } sched_cmd_type;

   typedef struct {
      logic [prq_pkg::ID_W-1:0]    id;
      logic                        valid;
      logic                        resched;
      logic [prq_pkg::COUNT_W-1:0] count;
      prq_pkg::status_type         status;
   } sched_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [1:0]                    req_opcode = prq_pkg::OP_TICK;
   logic [prq_pkg::ID_W-1:0]      req_task_id = '0;
   logic [prq_pkg::IN_PRIO_W-1:0] req_task_prio = '0;
   logic                          req_task_is_idle = 1'b0;
   logic                          req_was_runnable = 1'b0;
   logic                          req_last_tick = 1'b0;
   logic                          rsp_strobe;
   logic [prq_pkg::ID_W-1:0]      rsp_out_task_id;
   logic                          rsp_out_valid;
   logic                          rsp_resched_request;
   logic [prq_pkg::COUNT_W-1:0]   rsp_runnable_count;
   logic [1:0]                    rsp_status;
   logic                          csr_we = 1'b0;
   logic                          csr_wdata = 1'b0;

   priority_run_queue_scheduler_core u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_task_id         (req_task_id),
      .req_task_prio       (req_task_prio),
      .req_task_is_idle    (req_task_is_idle),
      .req_was_runnable    (req_was_runnable),
      .req_last_tick       (req_last_tick),
      .rsp_strobe          (rsp_strobe),
      .rsp_out_task_id     (rsp_out_task_id),
      .rsp_out_valid       (rsp_out_valid),
      .rsp_resched_request (rsp_resched_request),
      .rsp_runnable_count  (rsp_runnable_count),
      .rsp_status          (rsp_status),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // Shadow scheduler state. The queue arrays hold the sorted run queue, head
   // at index zero; only entries below rq_len are ever read.
   // ------------------------------------------------------------------------
   logic [prq_pkg::ID_W-1:0]      rq_ids   [prq_pkg::MAX_TASKS_DEF];
   logic [prq_pkg::IN_PRIO_W-1:0] rq_prios [prq_pkg::MAX_TASKS_DEF];
   int                            rq_len = 0;
   logic                          queued_flag [prq_pkg::NUM_IDS];
   logic                          front_flag  [prq_pkg::NUM_IDS];
   logic [prq_pkg::ID_W-1:0]      cur_task_id = '0;
   logic [prq_pkg::IN_PRIO_W-1:0] cur_task_prio = '0;
   logic                          cur_task_idle = 1'b1;
   int                            runnable_cnt = 0;
   logic                          resched_pending = 1'b0;
   logic                          preempt_on = 1'b1;

   sched_cmd_type    pending_cmds[$];
   sched_result_type results_due[$];
   sched_cmd_type    active_cmd;

   int mismatches = 0;
   int results_seen = 0;
   int tasks_returned = 0;
   int resched_seen = 0;
   int peak_count = 0;
   int peak_len = 0;
   int ops_taken [4];
   int settle_cnt = 0;
   int cycle_count = 0;

   initial begin
      for (int i = 0; i < prq_pkg::NUM_IDS; i++) begin
         queued_flag[i] = 1'b0;
         front_flag[i]  = 1'b0;
      end
      for (int i = 0; i < 4; i++) ops_taken[i] = 0;
   end

   // Works out the result of one accepted item and advances the shadow state.
   function automatic sched_result_type predict_sched_result(sched_cmd_type c);
      sched_result_type r;
      int               pos;
      r.id     = '0;
      r.valid  = 1'b0;
      r.status = prq_pkg::STAT_DONE;
      case (c.op)
         prq_pkg::OP_ENQUEUE: begin
            if (queued_flag[c.id] || c.idle) begin
               r.status = prq_pkg::STAT_IGNORED;
            end else if (rq_len >= prq_pkg::MAX_TASKS_DEF) begin
               // The front mark survives a dropped enqueue.
               r.status = prq_pkg::STAT_FULL;
            end else begin
               pos = 0;
               if (front_flag[c.id] == prq_pkg::FRONT_MARK_SET) begin
                  // A preempted task goes back ahead of its equals.
                  front_flag[c.id] = 1'b0;
                  while (pos < rq_len && rq_prios[pos] < c.prio) pos++;
               end else begin
                  while (pos < rq_len && rq_prios[pos] <= c.prio) pos++;
               end
               for (int i = rq_len; i > pos; i--) begin
                  rq_ids[i]   = rq_ids[i-1];
                  rq_prios[i] = rq_prios[i-1];
               end
               rq_ids[pos]   = c.id;
               rq_prios[pos] = c.prio;
               rq_len++;
               queued_flag[c.id] = 1'b1;
               if (!c.was_run) begin
                  if (runnable_cnt < 63) runnable_cnt++;
                  if (preempt_on && !cur_task_idle && c.prio < cur_task_prio) begin
                     resched_pending = 1'b1;
                     front_flag[cur_task_id] = prq_pkg::FRONT_MARK_SET;
                  end
               end
            end
         end
         prq_pkg::OP_PICK: begin
            if (rq_len > 0) begin
               r.id          = rq_ids[0];
               r.valid       = 1'b1;
               cur_task_id   = rq_ids[0];
               cur_task_prio = rq_prios[0];
               cur_task_idle = 1'b0;
               queued_flag[rq_ids[0]] = 1'b0;
               for (int i = 1; i < rq_len; i++) begin
                  rq_ids[i-1]   = rq_ids[i];
                  rq_prios[i-1] = rq_prios[i];
               end
               rq_len--;
            end else begin
               // Nothing to run: the idle task takes over.
               cur_task_id   = '0;
               cur_task_prio = '0;
               cur_task_idle = 1'b1;
            end
            resched_pending = 1'b0;
         end
         prq_pkg::OP_TICK: begin
            if (!cur_task_idle && c.last && runnable_cnt > 0) runnable_cnt--;
         end
         default: begin
            if (rq_len > 0) begin
               rq_len--;
               r.id    = rq_ids[rq_len];
               r.valid = 1'b1;
               queued_flag[rq_ids[rq_len]] = 1'b0;
               if (runnable_cnt > 0) runnable_cnt--;
            end
         end
      endcase
      r.resched = resched_pending;
      r.count   = prq_pkg::COUNT_W'(runnable_cnt);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus list builders.
   // ------------------------------------------------------------------------
   function automatic sched_cmd_type blank_cmd(cmd_kind_type kind);
      sched_cmd_type c;
      c.kind    = kind;
      c.op      = prq_pkg::OP_TICK;
      c.id      = '0;
      c.prio    = '0;
      c.idle    = 1'b0;
      c.was_run = 1'b0;
      c.last    = 1'b0;
      c.csr_val = 1'b0;
      c.gap_pct = 0;
      return c;
   endfunction

   function automatic void add_item(prq_pkg::op_type op, int id, int prio, bit idle,
                                    bit was_run, bit last, int gap_pct);
      sched_cmd_type c;
      c.kind    = CMD_ITEM;
      c.op      = op;
      c.id      = prq_pkg::ID_W'(id);
      c.prio    = prq_pkg::IN_PRIO_W'(prio);
      c.idle    = idle;
      c.was_run = was_run;
      c.last    = last;
      c.csr_val = 1'b0;
      c.gap_pct = gap_pct;
      pending_cmds.push_back(c);
   endfunction

   function automatic void add_pause();
      pending_cmds.push_back(blank_cmd(CMD_PAUSE));
   endfunction

   // A register write is only issued once the block has gone quiet.
   function automatic void add_csr_write(bit value);
      sched_cmd_type c;
      add_pause();
      c         = blank_cmd(CMD_CSR);
      c.csr_val = value;
      pending_cmds.push_back(c);
   endfunction

   // Half the priorities come from narrow bands at both ends so that ties, and
   // with them the front-insert rule, happen often.
   function automatic int rand_prio();
      int sel;
      sel = $urandom_range(3);
      if (sel == 1) return $urandom_range(7);
      if (sel == 2) return 248 + $urandom_range(7);
      return $urandom_range(255);
   endfunction

   function automatic void add_rand_op(prq_pkg::op_type op, int gap_pct);
      add_item(op, $urandom_range(prq_pkg::NUM_IDS - 1), rand_prio(),
               ($urandom_range(15) == 0), ($urandom_range(3) == 0),
               1'($urandom_range(1)), gap_pct);
   endfunction

   // Random part of one phase: bursts that fill the queue, drain it, or mix
   // all operations, plus now and then a burst that queues every task id so
   // the queue runs completely full.
   function automatic int add_random_phase(int n_items, int gap_pct);
      int made;
      int mode;
      int burst;
      int roll;
      int ids [prq_pkg::NUM_IDS];
      int j;
      int tmp;
      made = 0;
      while (made < n_items) begin
         mode = $urandom_range(7);
         if (mode == 0) begin
            for (int i = 0; i < prq_pkg::NUM_IDS; i++) ids[i] = i;
            for (int i = prq_pkg::NUM_IDS - 1; i > 0; i--) begin
               j      = $urandom_range(i);
               tmp    = ids[i];
               ids[i] = ids[j];
               ids[j] = tmp;
            end
            for (int i = 0; i < prq_pkg::NUM_IDS; i++) begin
               add_item(prq_pkg::OP_ENQUEUE, ids[i], rand_prio(), 1'b0,
                        ($urandom_range(3) == 0), 1'($urandom_range(1)), gap_pct);
            end
            made += prq_pkg::NUM_IDS;
         end else begin
            burst = $urandom_range(40, 8);
            for (int k = 0; k < burst; k++) begin
               roll = $urandom_range(99);
               if (mode <= 3) begin
                  // Mostly enqueues: the queue grows.
                  if (roll < 65)      add_rand_op(prq_pkg::OP_ENQUEUE, gap_pct);
                  else if (roll < 80) add_rand_op(prq_pkg::OP_PICK, gap_pct);
                  else if (roll < 92) add_rand_op(prq_pkg::OP_TICK, gap_pct);
                  else                add_rand_op(prq_pkg::OP_STEAL, gap_pct);
               end else if (mode <= 5) begin
                  // Mostly removals: the queue empties and runs dry.
                  if (roll < 20)      add_rand_op(prq_pkg::OP_ENQUEUE, gap_pct);
                  else if (roll < 55) add_rand_op(prq_pkg::OP_PICK, gap_pct);
                  else if (roll < 75) add_rand_op(prq_pkg::OP_TICK, gap_pct);
                  else                add_rand_op(prq_pkg::OP_STEAL, gap_pct);
               end else begin
                  roll = $urandom_range(3);
                  add_rand_op(prq_pkg::op_type'(roll[1:0]), gap_pct);
               end
            end
            made += burst;
         end
         if ($urandom_range(9) == 0) add_pause();
      end
      return made;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: presents one item at a time and holds it until the block takes
   // it. Acceptance is judged from start and busy as they stand at the edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic             nxt_start;
      logic             nxt_we;
      sched_cmd_type    c;
      sched_result_type r;
      nxt_start = start;
      nxt_we    = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            r = predict_sched_result(active_cmd);
            results_due.push_back(r);
            ops_taken[active_cmd.op]++;
            if (rq_len > peak_len) peak_len = rq_len;
            nxt_start = 1'b0;
         end
         if (!nxt_start && pending_cmds.size() > 0) begin
            c = pending_cmds[0];
            case (c.kind)
               CMD_ITEM: begin
                  if ($urandom_range(99) >= c.gap_pct) begin
                     active_cmd       = c;
                     req_opcode       <= c.op;
                     req_task_id      <= c.id;
                     req_task_prio    <= c.prio;
                     req_task_is_idle <= c.idle;
                     req_was_runnable <= c.was_run;
                     req_last_tick    <= c.last;
                     nxt_start        = 1'b1;
                     void'(pending_cmds.pop_front());
                  end
               end
               CMD_PAUSE: begin
                  // Hold off until every predicted result is in and the
                  // block has stayed quiet for the settle time.
                  if (results_due.size() == 0 && !busy) begin
                     if (settle_cnt >= SETTLE_CYCLES) begin
                        settle_cnt = 0;
                        void'(pending_cmds.pop_front());
                     end else begin
                        settle_cnt++;
                     end
                  end else begin
                     settle_cnt = 0;
                  end
               end
               default: begin
                  nxt_we     = 1'b1;
                  csr_wdata  <= c.csr_val;
                  preempt_on = c.csr_val;
                  void'(pending_cmds.pop_front());
               end
            endcase
         end
      end
      start  <= nxt_start;
      csr_we <= nxt_we;
   end

   // ------------------------------------------------------------------------
   // Monitor: every strobed result is matched against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      sched_result_type e;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display({"Result with no item pending: ",
                         "id=%0d valid=%0b resched=%0b count=%0d status=%0d"},
                        rsp_out_task_id, rsp_out_valid, rsp_resched_request,
                        rsp_runnable_count, rsp_status);
         end else begin
            e = results_due.pop_front();
            if (rsp_out_task_id !== e.id || rsp_out_valid !== e.valid ||
                rsp_resched_request !== e.resched || rsp_runnable_count !== e.count ||
                rsp_status !== e.status) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display({"Mismatch on result %0d: ",
                            "expected id=%0d valid=%0b resched=%0b count=%0d status=%0d, ",
                            "got id=%0d valid=%0b resched=%0b count=%0d status=%0d"},
                           results_seen, e.id, e.valid, e.resched, e.count, e.status,
                           rsp_out_task_id, rsp_out_valid, rsp_resched_request,
                           rsp_runnable_count, rsp_status);
            end
            if (rsp_out_valid === 1'b1) tasks_returned++;
            if (rsp_resched_request === 1'b1) resched_seen++;
            if (int'(rsp_runnable_count) > peak_count) peak_count = rsp_runnable_count;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, results_due.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      int made;

      // Directed part, preemption at its reset value of one.
      add_item(prq_pkg::OP_PICK,    0,   0, 1'b0, 1'b0, 1'b0, 0);  // pick on an empty queue
      add_item(prq_pkg::OP_STEAL,   0,   0, 1'b0, 1'b0, 1'b0, 0);  // steal on an empty queue
      add_item(prq_pkg::OP_TICK,    0,   0, 1'b0, 1'b0, 1'b1, 0);  // last tick while idle
      add_item(prq_pkg::OP_ENQUEUE, 3,  40, 1'b1, 1'b0, 1'b0, 0);  // idle task is ignored
      add_item(prq_pkg::OP_ENQUEUE, 0, 255, 1'b0, 1'b0, 1'b0, 0);
      add_item(prq_pkg::OP_ENQUEUE, 0, 100, 1'b0, 1'b0, 1'b0, 0);  // already queued
      add_item(prq_pkg::OP_ENQUEUE, 31,  0, 1'b0, 1'b1, 1'b1, 0);  // already runnable
      add_item(prq_pkg::OP_ENQUEUE, 9, 255, 1'b0, 1'b0, 1'b0, 0);  // ties go behind
      add_item(prq_pkg::OP_PICK,    0,   0, 1'b0, 1'b0, 1'b0, 0);
      add_item(prq_pkg::OP_ENQUEUE, 12,  0, 1'b0, 1'b0, 1'b0, 0);  // equal, no preemption
      add_item(prq_pkg::OP_PICK,    0,   0, 1'b0, 1'b0, 1'b0, 0);
      add_item(prq_pkg::OP_PICK,    0,   0, 1'b0, 1'b0, 1'b0, 0);  // current now prio 255
      add_item(prq_pkg::OP_ENQUEUE, 17, 254, 1'b0, 1'b0, 1'b0, 0); // preempts, marks current
      add_item(prq_pkg::OP_ENQUEUE, 0, 255, 1'b0, 1'b1, 1'b0, 0);  // front insert ahead of 9
      add_item(prq_pkg::OP_TICK,    0,   0, 1'b0, 1'b0, 1'b0, 0);
      add_item(prq_pkg::OP_TICK,    0,   0, 1'b0, 1'b0, 1'b1, 0);
      add_item(prq_pkg::OP_STEAL,   0,   0, 1'b0, 1'b0, 1'b0, 0);
      add_item(prq_pkg::OP_PICK,    0,   0, 1'b0, 1'b0, 1'b0, 0);  // clears the request
      add_item(prq_pkg::OP_STEAL,   0,   0, 1'b0, 1'b0, 1'b0, 0);
      add_item(prq_pkg::OP_STEAL,   0,   0, 1'b0, 1'b0, 1'b0, 0);
      add_item(prq_pkg::OP_ENQUEUE, 31, 128, 1'b0, 1'b0, 1'b1, 30);
      add_item(prq_pkg::OP_PICK,    0,   0, 1'b0, 1'b0, 1'b0, 30);
      add_item(prq_pkg::OP_TICK,    0,   0, 1'b0, 1'b0, 1'b1, 30);
      add_item(prq_pkg::OP_PICK,    0,   0, 1'b0, 1'b0, 1'b0, 30); // back to idle
      add_item(prq_pkg::OP_TICK,    0,   0, 1'b0, 1'b0, 1'b1, 30);

      // With preemption off a more urgent wakeup raises no request.
      add_csr_write(1'b0);
      add_item(prq_pkg::OP_ENQUEUE, 5, 200, 1'b0, 1'b0, 1'b0, 0);
      add_item(prq_pkg::OP_PICK,    0,   0, 1'b0, 1'b0, 1'b0, 0);
      add_item(prq_pkg::OP_ENQUEUE, 6,   1, 1'b0, 1'b0, 1'b0, 0);

      // Random phases: the sender idles often, then more often, then never.
      made = 0;
      add_csr_write(1'b1);
      made += add_random_phase(570, 38);
      add_csr_write(1'b0);
      made += add_random_phase(570, 52);
      add_csr_write(1'b1);
      made += add_random_phase(570, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() > 0 || start || results_due.size() > 0)
         @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      if (results_due.size() > 0) begin
         $display("%0d predicted results never arrived", results_due.size());
         mismatches += results_due.size();
      end
      $display("Covered %0d items (%0d enqueue, %0d pick, %0d tick, %0d steal), %0d random",
               ops_taken[0] + ops_taken[1] + ops_taken[2] + ops_taken[3],
               ops_taken[0], ops_taken[1], ops_taken[2], ops_taken[3], made);
      $display({"%0d tasks returned, %0d results with reschedule set, ",
                "peak count %0d, peak queue %0d, %0d mismatches"},
               tasks_returned, resched_seen, peak_count, peak_len, mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
